// ----- src/snll_pkg.sv -----
package snll_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 65536;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [7:0] TYPE_SOURCE = 8'h64;
    localparam logic [7:0] TYPE_LINE   = 8'h44;
    localparam logic [7:0] TYPE_FUNC   = 8'h24;

    localparam logic [1:0] CFG_LOOKUP_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_PREFERRED_BASE = 2'd1;
    localparam logic [1:0] CFG_LOAD_BASE      = 2'd2;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_SOURCE = 2'd1,
        OP_LINE   = 2'd2,
        OP_FUNC   = 2'd3
    } op_t;

    // value carries the rebased function start for OP_FUNC
    typedef struct packed {
        op_t         op;
        logic        empty;
        logic [31:0] name;
        logic [31:0] value;
        logic [15:0] line;
        logic        last;
    } item_t;

endpackage

// ----- src/snll_front.sv -----
module snll_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           entry_type,
    input  logic                 name_empty,
    input  logic [31:0]          name_offset,
    input  logic [31:0]          entry_value,
    input  logic [15:0]          entry_line,
    input  logic                 last_entry,
    output logic                 push_valid,
    output snll_pkg::item_t      push_item,
    input  logic                 q_full,
    output logic [31:0]          lookup_address
);
    import snll_pkg::*;

    logic [31:0] lookup_reg;
    logic [31:0] pref_base_reg;
    logic [31:0] load_base_reg;
    logic        valid_reg;
    logic        valid_next;
    item_t       item_reg;
    item_t       item_next;
    logic        load;
    logic [31:0] rebased;

    assign load       = !(valid_reg && q_full);
    assign in_stall   = !load;
    assign push_valid = valid_reg && !q_full;
    assign push_item  = item_reg;
    assign lookup_address = lookup_reg;

    assign rebased = entry_value - pref_base_reg + load_base_reg;

    always_comb
    begin
        item_next       = item_reg;
        valid_next      = valid_reg;
        if (load)
        begin
            valid_next      = in_valid;
            item_next.empty = name_empty;
            item_next.name  = name_offset;
            item_next.value = entry_value;
            item_next.line  = entry_line;
            item_next.last  = last_entry;
            case (entry_type)
                TYPE_SOURCE: item_next.op = OP_SOURCE;
                TYPE_LINE:   item_next.op = OP_LINE;
                TYPE_FUNC:
                begin
                    item_next.op    = OP_FUNC;
                    item_next.value = rebased;
                end
                default:     item_next.op = OP_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            lookup_reg    <= '0;
            pref_base_reg <= '0;
            load_base_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_LOOKUP_ADDRESS: lookup_reg    <= cfg_data;
                    CFG_PREFERRED_BASE: pref_base_reg <= cfg_data;
                    CFG_LOAD_BASE:      load_base_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ----- src/snll_queue.sv -----
module snll_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  snll_pkg::item_t push_item,
    output logic            full,
    output logic            q_valid,
    output snll_pkg::item_t q_item,
    input  logic            pop
);
    import snll_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push_valid && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- src/snll_back.sv -----
module snll_back
#(
    parameter int unsigned MAX_ENTRIES = snll_pkg::MAX_ENTRIES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  snll_pkg::item_t q_item,
    output logic            pop,
    input  logic [31:0]     lookup_address,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            found,
    output logic [15:0]     line_number,
    output logic [31:0]     dir_offset,
    output logic [31:0]     file_offset
);
    import snll_pkg::*;

    localparam int unsigned LIM_RAW = MAX_ENTRIES - 1;
    localparam logic [15:0] CNT_LIMIT =
        (LIM_RAW < 32'(CNT_MAX)) ? 16'(LIM_RAW) : CNT_MAX;

    logic        dir_active_reg,  dir_active_next;
    logic [31:0] cur_dir_reg,     cur_dir_next;
    logic        file_active_reg, file_active_next;
    logic [31:0] cur_file_reg,    cur_file_next;
    logic [31:0] func_start_reg,  func_start_next;
    logic [31:0] best_dist_reg,   best_dist_next;
    logic [31:0] best_dir_reg,    best_dir_next;
    logic [31:0] best_file_reg,   best_file_next;
    logic [15:0] best_line_reg,   best_line_next;
    logic [15:0] best_index_reg,  best_index_next;
    logic [15:0] count_reg,       count_next;

    logic        out_valid_reg,   out_valid_next;
    logic        found_reg,       found_next;
    logic [15:0] line_reg,        line_next;
    logic [31:0] dir_reg,         dir_next;
    logic [31:0] file_reg,        file_next;

    logic        out_free;
    logic [31:0] target;
    logic [31:0] cand_dist;
    logic        better;
    logic        is_found;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = q_valid && (!q_item.last || out_free);
    assign target    = func_start_reg + q_item.value;
    assign cand_dist = lookup_address - target;
    assign better    = (target <= lookup_address) && (cand_dist < best_dist_reg);

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign line_number = line_reg;
    assign dir_offset  = dir_reg;
    assign file_offset = file_reg;

    always_comb
    begin
        dir_active_next  = dir_active_reg;
        cur_dir_next     = cur_dir_reg;
        file_active_next = file_active_reg;
        cur_file_next    = cur_file_reg;
        func_start_next  = func_start_reg;
        best_dist_next   = best_dist_reg;
        best_dir_next    = best_dir_reg;
        best_file_next   = best_file_reg;
        best_line_next   = best_line_reg;
        best_index_next  = best_index_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        line_next        = line_reg;
        dir_next         = dir_reg;
        file_next        = file_reg;
        is_found         = 1'b0;

        if (pop)
        begin
            case (q_item.op)
                OP_SOURCE:
                begin
                    if (q_item.empty)
                    begin
                        dir_active_next  = 1'b0;
                        cur_dir_next     = '0;
                        file_active_next = 1'b0;
                        cur_file_next    = '0;
                    end
                    else if (!dir_active_reg)
                    begin
                        dir_active_next = 1'b1;
                        cur_dir_next    = q_item.name;
                        func_start_next = '0;
                    end
                    else
                    begin
                        file_active_next = 1'b1;
                        cur_file_next    = q_item.name;
                    end
                end
                OP_LINE:
                begin
                    if (dir_active_reg && file_active_reg && better)
                    begin
                        best_dist_next  = cand_dist;
                        best_dir_next   = cur_dir_reg;
                        best_file_next  = cur_file_reg;
                        best_line_next  = q_item.line;
                        best_index_next = count_reg;
                    end
                end
                OP_FUNC:
                begin
                    func_start_next = q_item.value;
                end
                default: ;
            endcase

            if (count_reg < CNT_LIMIT)
            begin
                count_next = count_reg + 16'd1;
            end

            if (q_item.last)
            begin
                is_found       = (best_index_next != '0);
                out_valid_next = 1'b1;
                found_next     = is_found;
                line_next      = is_found ? best_line_next : '0;
                dir_next       = is_found ? best_dir_next  : '0;
                file_next      = is_found ? best_file_next : '0;

                dir_active_next  = 1'b0;
                cur_dir_next     = '0;
                file_active_next = 1'b0;
                cur_file_next    = '0;
                func_start_next  = '0;
                best_dist_next   = '1;
                best_dir_next    = '0;
                best_file_next   = '0;
                best_line_next   = '0;
                best_index_next  = '0;
                count_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_active_reg  <= 1'b0;
            cur_dir_reg     <= '0;
            file_active_reg <= 1'b0;
            cur_file_reg    <= '0;
            func_start_reg  <= '0;
            best_dist_reg   <= '1;
            best_dir_reg    <= '0;
            best_file_reg   <= '0;
            best_line_reg   <= '0;
            best_index_reg  <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            dir_active_reg  <= dir_active_next;
            cur_dir_reg     <= cur_dir_next;
            file_active_reg <= file_active_next;
            cur_file_reg    <= cur_file_next;
            func_start_reg  <= func_start_next;
            best_dist_reg   <= best_dist_next;
            best_dir_reg    <= best_dir_next;
            best_file_reg   <= best_file_next;
            best_line_reg   <= best_line_next;
            best_index_reg  <= best_index_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        line_reg  <= line_next;
        dir_reg   <= dir_next;
        file_reg  <= file_next;
    end

endmodule

// ----- src/stab_nearest_line_lookup.sv -----
// Nearest source line lookup over a stream of stabs symbol entries.
// Input channel: one symbol entry per beat (in_valid/in_stall); last_entry
// closes a table. Output channel: one beat per table (out_valid/out_stall)
// with found, line_number, dir_offset and file_offset; fields are zero when
// nothing matched.
// Config: cfg_write with cfg_index 0 lookup address, 1 preferred base,
// 2 load base; write only while no table is in flight.
// Throughput: one entry per cycle while in_stall is low. The result beat is
// registered; the last entry passes the input register, then a two-entry
// queue, then the match unit with its output register.
// While out_stall is high, non-last entries keep flowing through the match
// unit; a last entry waits in the queue until the output register frees, and
// in_stall rises once the queue and input register fill.
// Reset clears config registers to zero, empties the queue and output, and
// returns all scan state to its initial value.
module stab_nearest_line_lookup
#(
    parameter int unsigned MAX_ENTRIES = snll_pkg::MAX_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  entry_type,
    input  logic        name_empty,
    input  logic [31:0] name_offset,
    input  logic [31:0] entry_value,
    input  logic [15:0] entry_line,
    input  logic        last_entry,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [15:0] line_number,
    output logic [31:0] dir_offset,
    output logic [31:0] file_offset
);
    import snll_pkg::*;

    logic        push_valid;
    item_t       push_item;
    logic        q_full;
    logic        q_valid;
    item_t       q_item;
    logic        pop;
    logic [31:0] lookup_address;

    snll_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .entry_type     (entry_type),
        .name_empty     (name_empty),
        .name_offset    (name_offset),
        .entry_value    (entry_value),
        .entry_line     (entry_line),
        .last_entry     (last_entry),
        .push_valid     (push_valid),
        .push_item      (push_item),
        .q_full         (q_full),
        .lookup_address (lookup_address)
    );

    snll_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop)
    );

    snll_back
    #(
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .lookup_address (lookup_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .line_number    (line_number),
        .dir_offset     (dir_offset),
        .file_offset    (file_offset)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import snll_pkg::*;

    localparam int unsigned TB_MAX_ENTRIES = MAX_ENTRIES_DEF;
    localparam logic [15:0] IDX_CAP =
        (TB_MAX_ENTRIES - 1 < 32'(CNT_MAX)) ? 16'(TB_MAX_ENTRIES - 1) : CNT_MAX;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_ENTRIES = 900;
    localparam int LONG_NOISE     = 60;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0]  kind;
        logic        empty;
        logic [31:0] name;
        logic [31:0] value;
        logic [15:0] line;
        logic        last;
    } sym_entry_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] line;
        logic [31:0] dir;
        logic [31:0] file;
    } line_match_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  entry_type;
    logic        name_empty;
    logic [31:0] name_offset;
    logic [31:0] entry_value;
    logic [15:0] entry_line;
    logic        last_entry;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [15:0] line_number;
    logic [31:0] dir_offset;
    logic [31:0] file_offset;

    stab_nearest_line_lookup #(
        .MAX_ENTRIES(TB_MAX_ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .entry_type(entry_type),
        .name_empty(name_empty),
        .name_offset(name_offset),
        .entry_value(entry_value),
        .entry_line(entry_line),
        .last_entry(last_entry),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .line_number(line_number),
        .dir_offset(dir_offset),
        .file_offset(file_offset)
    );

    always #5 clk = ~clk;

    // predicted scan state
    logic [31:0] lookup_addr_m = '0;
    logic [31:0] pref_base_m   = '0;
    logic [31:0] load_base_m   = '0;
    logic        in_dir;
    logic [31:0] dir_name;
    logic        in_file;
    logic [31:0] file_name;
    logic [31:0] func_base;
    logic [31:0] near_dist;
    logic [31:0] near_dir;
    logic [31:0] near_file;
    logic [15:0] near_line;
    logic [15:0] near_idx;
    logic [15:0] entry_idx;

    line_match_t pending_matches[$];

    int fail_count    = 0;
    int lookups_done  = 0;
    int lookups_hit   = 0;
    int entries_sent  = 0;
    int config_sets   = 0;
    int quiet_cycles  = 0;

    int burst_left    = 0;
    int burst_max     = 8;
    int gap_max       = 3;
    int stall_pct     = 20;
    int stall_run_max = 6;
    int hold_left     = 0;

    task automatic clear_scan_model();
        in_dir    = 1'b0;
        dir_name  = '0;
        in_file   = 1'b0;
        file_name = '0;
        func_base = '0;
        near_dist = '1;
        near_dir  = '0;
        near_file = '0;
        near_line = '0;
        near_idx  = '0;
        entry_idx = '0;
    endtask

    task automatic predict_lookup(input sym_entry_t e);
        logic [31:0] target;
        line_match_t m;
        target = func_base + e.value;
        case (e.kind)
            TYPE_SOURCE:
            begin
                if (e.empty)
                begin
                    in_dir    = 1'b0;
                    dir_name  = '0;
                    in_file   = 1'b0;
                    file_name = '0;
                end
                else if (!in_dir)
                begin
                    in_dir    = 1'b1;
                    dir_name  = e.name;
                    func_base = '0;
                end
                else
                begin
                    in_file   = 1'b1;
                    file_name = e.name;
                end
            end
            TYPE_LINE:
            begin
                if (in_dir && in_file && target <= lookup_addr_m
                    && (lookup_addr_m - target) < near_dist)
                begin
                    near_dist = lookup_addr_m - target;
                    near_dir  = dir_name;
                    near_file = file_name;
                    near_line = e.line;
                    near_idx  = entry_idx;
                end
            end
            TYPE_FUNC:
            begin
                func_base = e.value - pref_base_m + load_base_m;
            end
            default:
            begin
            end
        endcase
        if (entry_idx < IDX_CAP)
            entry_idx++;
        if (e.last)
        begin
            m = '0;
            if (near_idx != 0)
            begin
                m.hit  = 1'b1;
                m.line = near_line;
                m.dir  = near_dir;
                m.file = near_file;
            end
            pending_matches.push_back(m);
            clear_scan_model();
        end
    endtask

    function automatic sym_entry_t sym(input logic [7:0] kind, input logic empty,
                                       input logic [31:0] name, input logic [31:0] value,
                                       input logic [15:0] line, input logic last);
        sym_entry_t e;
        e = {kind, empty, name, value, line, last};
        return e;
    endfunction

    function automatic logic [7:0] noise_kind();
        logic [7:0] k;
        do
            k = 8'($urandom_range(0, 255));
        while (k == TYPE_SOURCE || k == TYPE_LINE || k == TYPE_FUNC);
        return k;
    endfunction

    task automatic note_mismatch(input string what, input line_match_t want,
                                 input line_match_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display({"%s: expected found=%0b line=%0d dir=%h file=%h, ",
                      "got found=%0b line=%0d dir=%h file=%h"},
                     what, want.hit, want.line, want.dir, want.file,
                     got.hit, got.line, got.dir, got.file);
    endtask

    task automatic set_idling(input int gap, input int burst, input int pct, input int run);
        gap_max       = gap;
        burst_max     = burst;
        stall_pct     = pct;
        stall_run_max = run;
    endtask

    task automatic send_entry(input sym_entry_t e);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        entry_type  <= e.kind;
        name_empty  <= e.empty;
        name_offset <= e.name;
        entry_value <= e.value;
        entry_line  <= e.line;
        last_entry  <= e.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_lookup(e);
        entries_sent++;
    endtask

    // sender holds off until every pending lookup has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_config(input logic [31:0] lookup, input logic [31:0] pref,
                              input logic [31:0] load);
        cfg_write <= 1'b1;
        cfg_index <= CFG_LOOKUP_ADDRESS;
        cfg_data  <= lookup;
        @(posedge clk);
        cfg_index <= CFG_PREFERRED_BASE;
        cfg_data  <= pref;
        @(posedge clk);
        cfg_index <= CFG_LOAD_BASE;
        cfg_data  <= load;
        @(posedge clk);
        cfg_write <= 1'b0;
        lookup_addr_m = lookup;
        pref_base_m   = pref;
        load_base_m   = load;
        config_sets++;
    endtask

    task automatic test_directed_tables();
        set_idling(2, 4, 25, 5);
        set_config(32'h0000_1050, '0, '0);
        // line before any directory is ignored, then nearest wins, ties keep first
        send_entry(sym(TYPE_LINE, 1'b0, 32'h1, 32'h1050, 16'd99, 1'b0));
        send_entry(sym(TYPE_SOURCE, 1'b0, 32'h10, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_SOURCE, 1'b0, 32'h20, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_FUNC, 1'b0, 32'h30, 32'h1000, 16'd0, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, 32'h0, 32'h40, 16'd10, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, 32'h0, 32'h60, 16'd11, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, 32'h0, 32'h50, 16'd12, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, 32'h0, 32'h50, 16'd13, 1'b0));
        send_entry(sym(8'hFF, 1'b1, '1, '1, '1, 1'b1));
        drain_results();

        // rebased start wraps to 1, line lands on the top address
        set_config('1, '1, '0);
        send_entry(sym(TYPE_SOURCE, 1'b0, 32'h0, '1, '1, 1'b0));
        send_entry(sym(TYPE_SOURCE, 1'b0, '1, '0, '0, 1'b0));
        send_entry(sym(TYPE_FUNC, 1'b1, '0, '0, '0, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b1, '1, 32'hFFFF_FFFE, 16'hFFFF, 1'b1));
        drain_results();

        // line address wraps past zero
        set_config(32'h10, 32'h1000, '0);
        send_entry(sym(TYPE_SOURCE, 1'b0, 32'hA, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_SOURCE, 1'b0, 32'hB, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_FUNC, 1'b0, 32'hC, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, 32'h0, 32'h1008, 16'd7, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, 32'h0, 32'h2000, 16'd8, 1'b1));
        // one-entry table, then empty names clearing directory and file
        send_entry(sym(TYPE_FUNC, 1'b0, 32'h0, 32'h5, 16'd1, 1'b1));
        send_entry(sym(TYPE_SOURCE, 1'b1, 32'h5, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_SOURCE, 1'b0, '1, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_SOURCE, 1'b1, 32'h6, 32'h0, 16'd0, 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, 32'h0, 32'h0, 16'd3, 1'b1));
        drain_results();
    endtask

    task automatic test_random_tables();
        int phase;
        int sent;
        int tables;
        int n;
        int r;
        sym_entry_t e;
        logic [31:0] start;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ENTRIES)
        begin
            case (phase % 6)
                0: set_config('0, '0, '0);
                1: set_config('1, '1, '1);
                2: set_config($urandom, $urandom, $urandom);
                3: set_config($urandom_range(0, 'hFF), '0, '0);
                4: set_config('1, '0, '1);
                default: set_config($urandom, '0, $urandom);
            endcase
            case (phase % 4)
                0: set_idling(0, 1, 0, 0);
                1: set_idling(2, 6, 15, 4);
                2: set_idling(1, 10, 40, 20);
                default: set_idling(8, 3, 10, 2);
            endcase
            for (tables = 0; tables < 8; tables++)
            begin
                n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
                                               : $urandom_range(13, 60);
                for (int i = 0; i < n; i++)
                begin
                    e.kind  = noise_kind();
                    e.empty = 1'($urandom_range(0, 1));
                    e.name  = $urandom;
                    e.value = $urandom;
                    e.line  = 16'($urandom_range(0, 65535));
                    e.last  = (i == n - 1);
                    r = $urandom_range(0, 99);
                    if (i < 2 && r < 85)
                    begin
                        e.kind  = TYPE_SOURCE;
                        e.empty = 1'b0;
                    end
                    else if (r < 8)
                        e.kind = TYPE_SOURCE;
                    else if (r < 20)
                    begin
                        e.kind = TYPE_FUNC;
                        if (r < 17)
                        begin
                            start   = lookup_addr_m - 32'($urandom_range(0, 'h400));
                            e.value = start + pref_base_m - load_base_m;
                        end
                    end
                    else if (r < 75)
                    begin
                        e.kind = TYPE_LINE;
                        if ($urandom_range(0, 4) != 0)
                            e.value = $urandom_range(0, 'h600);
                    end
                    else if (r >= 90)
                        e.kind = 8'($urandom_range(0, 255));
                    send_entry(e);
                    sent++;
                end
            end
            drain_results();
            phase++;
        end
    endtask

    // long table whose only match is its final entry
    task automatic test_long_table();
        logic [31:0] target;
        set_idling(1, 64, 5, 3);
        target = $urandom | 32'h1;
        set_config(target, '0, '0);
        send_entry(sym(TYPE_SOURCE, 1'b0, $urandom, $urandom, 16'd0, 1'b0));
        send_entry(sym(TYPE_SOURCE, 1'b0, $urandom, $urandom, 16'd0, 1'b0));
        repeat (LONG_NOISE)
            send_entry(sym(noise_kind(), 1'($urandom_range(0, 1)), $urandom, $urandom,
                           16'($urandom_range(0, 65535)), 1'b0));
        send_entry(sym(TYPE_LINE, 1'b0, $urandom, target, 16'($urandom_range(0, 65535)), 1'b1));
        drain_results();
    endtask

    always @(posedge clk)
    begin : check_results
        line_match_t got;
        line_match_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {found, line_number, dir_offset, file_offset};
            if (pending_matches.size() == 0)
                note_mismatch("unexpected result beat", '0, got);
            else
            begin
                want = pending_matches.pop_front();
                if (got !== want)
                    note_mismatch("result mismatch", want, got);
                lookups_done++;
                if (want.hit)
                    lookups_hit++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            hold_left <= $urandom_range(0, stall_run_max);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_matches.size());
            $display("stab_nearest_line_lookup regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_LOOKUP_ADDRESS;
        cfg_data    = '0;
        in_valid    = 1'b0;
        entry_type  = '0;
        name_empty  = 1'b0;
        name_offset = '0;
        entry_value = '0;
        entry_line  = '0;
        last_entry  = 1'b0;
        clear_scan_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_tables();
        test_random_tables();
        test_long_table();
        drain_results();

        while (pending_matches.size() != 0)
            note_mismatch("missing result", pending_matches.pop_front(), '0);
        $display("covered %0d lookups (%0d with a match) over %0d entries",
                 lookups_done, lookups_hit, entries_sent);
        $display("with %0d register settings and a long table matched at its end; %0d failures",
                 config_sets, fail_count);
        if (fail_count == 0)
            $display("stab_nearest_line_lookup regression: pass");
        else
            $display("stab_nearest_line_lookup regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/snll_pkg.sv
src/snll_front.sv
src/snll_queue.sv
src/snll_back.sv
src/stab_nearest_line_lookup.sv
tb/tb_top.sv
